// ----- rtl/core/gre_pkg.sv -----
// Package for the gamma run delta expander.
// Holds the controller state type, the command and status structs and fixed constants.
// No dependencies.
package gre_pkg;

    // Side store geometry, fixed by the six-bit slot field.
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = 6;

    // No more than this many results leave for one run code.
    localparam int MAX_RESULTS = 40;
    localparam int RES_W       = 6;

    // Run code layout.
    localparam int STEP_W = 3;
    localparam int LEN_W  = 5;

    // Input mode codes.
    localparam logic MODE_SIDE_WRITE = 1'b0;
    localparam logic MODE_RUN_CODE   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SIDE,
        ST_VALUE
    } gre_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_run;   // take a new run code
        logic side_write;  // write a side byte into the store
        logic load_side;   // present the fetched side byte
        logic advance;     // perform one step of the run
    } gre_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result
        logic truncated;   // result limit reached for this run code
        logic grp_zero;    // next curve value opens a group
        logic grp_wrap;    // the step under way closes a group
        logic run_end;     // the step under way is the final one
    } gre_status_t;

endpackage

// ----- rtl/core/gre_ctrl.sv -----
// Controller state machine of the gamma run delta expander.
// Depends on gre_pkg for the state type and the command and status structs.
module gre_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    input  gre_pkg::gre_status_t status,
    output gre_pkg::gre_cmd_t    cmd
);
    import gre_pkg::*;

    gre_state_t state_reg;
    gre_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_mode == MODE_RUN_CODE))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = status.grp_zero ? ST_SIDE : ST_VALUE;
            end
            ST_SIDE:
            begin
                if (status.out_free || status.truncated)
                begin
                    state_next = ST_VALUE;
                end
            end
            ST_VALUE:
            begin
                if (status.out_free || status.truncated)
                begin
                    if (status.run_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.grp_wrap)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.latch_run  = in_valid && (in_mode == MODE_RUN_CODE);
                cmd.side_write = in_valid && (in_mode == MODE_SIDE_WRITE);
            end
            ST_FETCH:
            begin
                cmd = '0;
            end
            ST_SIDE:
            begin
                cmd.load_side = status.out_free || status.truncated;
            end
            ST_VALUE:
            begin
                cmd.advance = status.out_free || status.truncated;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/gre_datapath.sv -----
// Datapath of the gamma run delta expander: side store, accumulator, counters
// and the output register. Depends on gre_pkg for constants and structs.
module gre_datapath
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int GROUP_SIZE    = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gre_pkg::gre_cmd_t    cmd,
    output gre_pkg::gre_status_t status,
    input  logic [5:0]           in_side_index,
    input  logic [7:0]           in_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_is_side,
    output logic                 out_last,
    output logic                 out_table_done
);
    import gre_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES);
    localparam int GRP_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    logic [7:0]        side_mem [STORE_DEPTH];
    logic [7:0]        rd_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [RES_W-1:0]  res_cnt_reg;
    logic [7:0]        acc_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_is_side_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    logic [7:0]        acc_sum;
    logic              table_end;
    logic              limit_last;
    logic              out_load;

    // Step arithmetic and end conditions.
    assign acc_sum    = acc_reg + {{(8 - STEP_W){1'b0}}, step_reg};
    assign table_end  = (count_reg == CNT_W'(TABLE_ENTRIES - 1));
    assign limit_last = (res_cnt_reg == RES_W'(MAX_RESULTS - 1));

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.truncated = (res_cnt_reg == RES_W'(MAX_RESULTS));
    assign status.grp_zero  = (grp_reg == '0);
    assign status.grp_wrap  = (grp_reg == GRP_W'(GROUP_SIZE - 1));
    assign status.run_end   = (len_reg == '0) || table_end;

    assign out_load = (cmd.load_side || cmd.advance) && !status.truncated;

    // Side store with registered read at the current slot.
    always_ff @(posedge clk)
    begin
        if (cmd.side_write)
        begin
            side_mem[in_side_index] <= in_value;
        end
        rd_reg <= side_mem[slot_reg];
    end

    // Run code registers; the run length is held as steps left minus one.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_run)
        begin
            step_reg <= in_value[7:LEN_W];
            len_reg  <= in_value[LEN_W-1:0];
        end
        else if (cmd.advance)
        begin
            len_reg <= len_reg - 1'b1;
        end
    end

    // Results counted per run code, up to the limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= '0;
        end
        else if (cmd.latch_run)
        begin
            res_cnt_reg <= '0;
        end
        else if (out_load)
        begin
            res_cnt_reg <= res_cnt_reg + 1'b1;
        end
    end

    // Curve state: accumulator, value count, position in group and side slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            grp_reg   <= '0;
            slot_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            if (table_end)
            begin
                acc_reg   <= '0;
                count_reg <= '0;
                grp_reg   <= '0;
                slot_reg  <= '0;
            end
            else
            begin
                acc_reg   <= acc_sum;
                count_reg <= count_reg + 1'b1;
                if (status.grp_wrap)
                begin
                    grp_reg  <= '0;
                    slot_reg <= slot_reg + 1'b1;
                end
                else
                begin
                    grp_reg <= grp_reg + 1'b1;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload: a side byte or the new curve value.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cmd.load_side)
            begin
                out_byte_reg    <= rd_reg;
                out_is_side_reg <= 1'b1;
                out_last_reg    <= limit_last;
                out_done_reg    <= 1'b0;
            end
            else
            begin
                out_byte_reg    <= acc_sum;
                out_is_side_reg <= 1'b0;
                out_last_reg    <= status.run_end || limit_last;
                out_done_reg    <= table_end;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_is_side    = out_is_side_reg;
    assign out_last       = out_last_reg;
    assign out_table_done = out_done_reg;

endmodule

// ----- rtl/core/gamma_run_delta_expander.sv -----
// Gamma run delta expander: side bytes load a 64-entry store, run codes expand
// into gamma table bytes. A side byte write gives no item. A run code of L steps
// sends up to L curve values; at each group start it first reads the side store through
// its registered port and then sends the side byte. The single output register sends
// one item per cycle while the output does not stall.
// A new item is taken only when the previous run code has finished.
// Depends on gre_pkg, gre_ctrl and gre_datapath.
module gamma_run_delta_expander
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int GROUP_SIZE    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] side_index, [13:6] value, [15:14] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] is_side, [1] table_done
    output logic        m_tlast
);
    import gre_pkg::*;

    gre_cmd_t    cmd;
    gre_status_t status;

    // Sequencing of the steps of each run code.
    gre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, curve arithmetic and output register.
    gre_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .GROUP_SIZE    (GROUP_SIZE)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_side_index  (s_tdata[5:0]),
        .in_value       (s_tdata[13:6]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_is_side    (m_tuser[0]),
        .out_last       (m_tlast),
        .out_table_done (m_tuser[1])
    );

endmodule

// ----- rtl/core/gre_checker.sv -----
// Port-level checks for the gamma run delta expander, bound to the top level.
// Depends only on the top level's port names.
module gre_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled output item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output item changed while stalled");

    // The final curve value of a table ends the items of its run code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("table end without last");

    // A side byte never carries the table end.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("side byte flagged as table end");

    // A run code keeps the input closed while it expands.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input open during run expansion");

endmodule

bind gamma_run_delta_expander gre_checker u_gre_checker (.*);
